FILE: rtl/core/dgcc_pkg.sv
package dgcc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int COUNT_W   = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W    = 2 * NODE_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] REG_NODE_LIMIT = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_REQ,
        S_POP_WAIT,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

FILE: rtl/core/dgcc_ram.sv
module dgcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/dependency_graph_cycle_check_top.sv
// A clear, a rejected add, or an add with the cycle flag already set presents
// its result in the cycle after acceptance.
// Any other accepted add runs a depth-first search. Each node is popped in
// S_POP_REQ and S_POP_WAIT and then, unless it is the goal, scanned against
// every held edge in S_SCAN.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is taken.
// Reset: rst_n is asynchronous and clears the edge count, the cycle flag and
// node_limit. The edge and stack memories are not cleared.
module dependency_graph_cycle_check_top
    import dgcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  from_node,
    input  logic [7:0]  to_node,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        cycle_present,
    output logic [8:0]  edges_stored
);

    state_t              state_reg, state_next;
    logic [6:0]          limit_reg;
    logic [COUNT_W-1:0]  held_reg, held_next;
    logic                cyc_reg, cyc_next;
    logic [MAX_NODES-1:0] vis_reg, vis_next;
    logic [NODE_W:0]     depth_reg, depth_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   goal_reg, goal_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [1:0]          st_reg, st_next;
    logic                ov_reg, ov_next;

    logic                e_we;
    logic [EDGE_AW-1:0]  e_waddr, e_raddr;
    logic [EDGE_W-1:0]   e_wdata, e_rdata;
    logic                s_we;
    logic [NODE_W-1:0]   s_waddr, s_raddr, s_rdata;
    logic [NODE_W-1:0]   s_rdata_in;

    logic                wr_en;
    logic [7:0]          eff_limit;
    logic                bad;
    logic [NODE_W-1:0]   e_src, e_dst;
    logic                rd_valid;

    dgcc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    dgcc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_rdata_in),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr == {REG_NODE_LIMIT[0], 1'b0}) ? {25'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (wr_en && paddr == {REG_NODE_LIMIT[0], 1'b0})
        begin
            limit_reg <= pwdata[6:0];
        end
    end

    assign eff_limit = (limit_reg > 7'(MAX_NODES)) ? 8'(MAX_NODES) : {1'b0, limit_reg};
    assign bad = (from_node >= eff_limit) || (to_node >= eff_limit) || (from_node == to_node);
    assign e_src = e_rdata[EDGE_W-1:NODE_W];
    assign e_dst = e_rdata[NODE_W-1:0];

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_RESULT);
    assign status        = st_reg;
    assign cycle_present = cyc_reg;
    assign edges_stored  = 9'(held_reg);

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        cyc_next   = cyc_reg;
        vis_next   = vis_reg;
        depth_next = depth_reg;
        node_next  = node_reg;
        goal_next  = goal_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        e_we       = 1'b0;
        e_waddr    = held_reg[EDGE_AW-1:0];
        e_wdata    = {from_node[NODE_W-1:0], to_node[NODE_W-1:0]};
        e_raddr    = idx_reg[EDGE_AW-1:0];
        s_we       = 1'b0;
        s_waddr    = depth_reg[NODE_W-1:0];
        s_rdata_in = to_node[NODE_W-1:0];
        s_raddr    = NODE_W'(depth_reg - 1'b1);
        rd_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next    = ST_OK;
                    state_next = S_RESULT;
                    if (mode)
                    begin
                        held_next = '0;
                        cyc_next  = 1'b0;
                    end
                    else if (bad)
                    begin
                        st_next = ST_INVALID;
                    end
                    else if (held_reg >= COUNT_W'(MAX_EDGES))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        e_we      = 1'b1;
                        held_next = held_reg + 1'b1;
                        if (!cyc_reg)
                        begin
                            vis_next = '0;
                            vis_next[to_node[NODE_W-1:0]] = 1'b1;
                            s_we       = 1'b1;
                            s_waddr    = '0;
                            depth_next = (NODE_W + 1)'(1);
                            goal_next  = from_node[NODE_W-1:0];
                            state_next = S_POP_REQ;
                        end
                    end
                end
            end
            S_POP_REQ:
            begin
                if (depth_reg == '0)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                node_next = s_rdata;
                if (s_rdata == goal_reg)
                begin
                    cyc_next   = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next   = '0;
                    ov_next    = 1'b0;
                    e_raddr    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // ov_reg marks that the edge read for idx_reg-1 is in e_rdata
                rd_valid = ov_reg;
                if (rd_valid && e_src == node_reg && !vis_reg[e_dst])
                begin
                    vis_next[e_dst] = 1'b1;
                    s_we       = 1'b1;
                    s_rdata_in = e_dst;
                    depth_next = depth_reg + 1'b1;
                end
                if (idx_reg >= held_reg)
                begin
                    state_next = S_POP_REQ;
                end
                else
                begin
                    e_raddr  = idx_reg[EDGE_AW-1:0];
                    idx_next = idx_reg + 1'b1;
                    ov_next  = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            cyc_reg   <= 1'b0;
            vis_reg   <= '0;
            depth_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            cyc_reg   <= cyc_next;
            vis_reg   <= vis_next;
            depth_reg <= depth_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        goal_reg <= goal_next;
        idx_reg  <= idx_next;
        st_reg   <= st_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= COUNT_W'(MAX_EDGES))
        else $error("edge count beyond capacity");
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= (NODE_W + 1)'(MAX_NODES))
        else $error("search stack overflow");
    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (cyc_reg && state_reg != S_IDLE) |=> cyc_reg)
        else $error("cycle flag dropped during an item");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(edges_stored)))
        else $error("result changed while stalled");
`endif

endmodule

FILE: bench/dependency_graph_cycle_check_top_tb.sv
`timescale 1ns / 1ps

module dependency_graph_cycle_check_top_tb;
    import dgcc_pkg::*;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam int   ITEM_GOAL  = 950;

    typedef struct packed {
        logic [1:0] status;
        logic       cycle_present;
        logic [8:0] edges_stored;
    } graph_result_t;

    class graph_scoreboard;
        logic [7:0]    src_tab[MAX_EDGES];
        logic [7:0]    dst_tab[MAX_EDGES];
        int unsigned   held;
        bit            cyc;
        int unsigned   node_lim;
        graph_result_t pending[$];
        int            errors;
        int            n_ok;
        int            n_invalid;
        int            n_full;
        int            n_cycle;

        function new();
            held = 0;
            cyc = 0;
            node_lim = 0;
            errors = 0;
            n_ok = 0;
            n_invalid = 0;
            n_full = 0;
            n_cycle = 0;
        endfunction

        function void set_limit(logic [6:0] value);
            node_lim = value;
        endfunction

        function bit path_exists(int unsigned start, int unsigned goal);
            logic [MAX_NODES-1:0] seen;
            int unsigned          stack[$];
            int unsigned          node;
            seen = '0;
            if (start >= MAX_NODES)
                return 0;
            seen[start] = 1'b1;
            stack.push_back(start);
            while (stack.size() > 0) begin
                node = stack.pop_back();
                if (node == goal)
                    return 1;
                for (int i = 0; i < held; i++) begin
                    if (src_tab[i] == node && dst_tab[i] < MAX_NODES && !seen[dst_tab[i]]) begin
                        seen[dst_tab[i]] = 1'b1;
                        stack.push_back(dst_tab[i]);
                    end
                end
            end
            return 0;
        endfunction

        function void note_input(logic m, logic [7:0] f, logic [7:0] t);
            int unsigned   lim;
            graph_result_t r;
            lim = (node_lim > MAX_NODES) ? MAX_NODES : node_lim;
            r.status = ST_OK;
            if (m == MODE_CLEAR) begin
                held = 0;
                cyc = 0;
            end
            else if (f >= lim || t >= lim || f == t)
                r.status = ST_INVALID;
            else if (held >= MAX_EDGES)
                r.status = ST_FULL;
            else begin
                src_tab[held] = f;
                dst_tab[held] = t;
                held++;
                if (!cyc && path_exists(t, f))
                    cyc = 1;
            end
            r.cycle_present = cyc;
            r.edges_stored = 9'(held);
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic cp, logic [8:0] cnt);
            graph_result_t e;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st != e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (cp != e.cycle_present) begin
                $error("cycle_present expected %0d actual %0d", e.cycle_present, cp);
                errors++;
            end
            if (cnt != e.edges_stored) begin
                $error("edges_stored expected %0d actual %0d", e.edges_stored, cnt);
                errors++;
            end
            case (e.status)
                ST_OK:      n_ok++;
                ST_INVALID: n_invalid++;
                default:    n_full++;
            endcase
            if (e.cycle_present)
                n_cycle++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  from_node;
    logic [7:0]  to_node;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        cycle_present;
    logic [8:0]  edges_stored;

    graph_scoreboard sb;
    int              items_sent;
    int unsigned     cur_limit;
    bit              no_idle;

    dependency_graph_cycle_check_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .from_node     (from_node),
        .to_node       (to_node),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .cycle_present (cycle_present),
        .edges_stored  (edges_stored)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned idle_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic send_item(logic m, logic [7:0] f, logic [7:0] t);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        from_node <= f;
        to_node   <= t;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_input(m, f, t);
        items_sent++;
        if ($urandom_range(0, 99) < 3)
            no_idle = !no_idle;
    endtask

    task automatic send_edge(int unsigned f, int unsigned t);
        send_item(MODE_ADD, 8'(f), 8'(t));
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_node_limit(logic [6:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_NODE_LIMIT * 4);
        pwdata  <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_limit(value);
        cur_limit = value;
    endtask

    task automatic send_good_edge();
        int unsigned lim;
        int unsigned f;
        int unsigned t;
        lim = (cur_limit > MAX_NODES) ? MAX_NODES : cur_limit;
        if (lim < 2) begin
            send_edge($urandom_range(0, 255), $urandom_range(0, 255));
            return;
        end
        f = $urandom_range(0, lim - 1);
        t = $urandom_range(0, lim - 2);
        if (t >= f)
            t++;
        send_edge(f, t);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_edge($urandom_range(0, 255), $urandom_range(0, 255));
            1: send_edge($urandom_range(0, 63), $urandom_range(0, 63));
            2:
            begin
                int unsigned n;
                n = $urandom_range(0, 255);
                send_edge(n, n);
            end
            default: send_clear();
        endcase
    endtask

    always
    begin : result_sink
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        do
            @(posedge clk);
        while (!(out_valid && out_ready));
        sb.check_result(status, cycle_present, edges_stored);
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [6:0] limits[$];
        int unsigned lim_pick;
        int unsigned run_len;
        sb = new();
        items_sent = 0;
        cur_limit = 0;
        no_idle = 0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        mode      = MODE_ADD;
        from_node = '0;
        to_node   = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit zero straight after reset: every add is rejected
        send_edge(0, 1);
        send_edge(255, 0);
        write_node_limit(7'd1);
        send_edge(0, 0);
        send_edge(0, 1);
        write_node_limit(7'd2);
        send_edge(0, 1);
        send_edge(1, 1);
        send_edge(2, 0);
        send_edge(0, 1);
        send_edge(1, 0);
        send_edge(0, 1);
        send_item(MODE_CLEAR, 8'hff, 8'hff);
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        write_node_limit(7'd127);
        send_edge(63, 0);
        send_edge(64, 0);
        send_edge(0, 64);
        send_edge(255, 254);
        send_edge(0, 63);
        send_edge(170, 85);
        send_clear();
        write_node_limit(7'd64);
        send_edge(10, 20);
        send_edge(20, 30);
        send_edge(30, 10);

        // fill the table to capacity with a tiny node set
        write_node_limit(7'd3);
        send_clear();
        repeat (MAX_EDGES + 4) send_good_edge();
        send_edge(5, 0);
        send_edge(1, 1);
        send_clear();

        limits = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd8, 7'd16, 7'd63, 7'd64, 7'd65,
                   7'd100, 7'd127};
        while (items_sent < ITEM_GOAL) begin
            lim_pick = $urandom_range(0, limits.size());
            if (lim_pick == limits.size())
                write_node_limit(7'($urandom_range(4, 63)));
            else
                write_node_limit(limits[lim_pick]);
            repeat ((cur_limit < 2) ? 1 : $urandom_range(2, 5)) begin
                send_clear();
                run_len = (cur_limit < 2) ? $urandom_range(3, 8) : $urandom_range(2, 40);
                repeat (run_len) begin
                    if ($urandom_range(0, 99) < 85)
                        send_good_edge();
                    else
                        send_noise();
                end
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.pending.size() > 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Ran %0d items: %0d ok, %0d invalid, %0d capacity exceeded",
                 items_sent, sb.n_ok, sb.n_invalid, sb.n_full);
        $display("Results with cycle flag set: %0d", sb.n_cycle);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: dependency_graph_cycle_check_top.f
rtl/core/dgcc_pkg.sv
rtl/core/dgcc_ram.sv
rtl/core/dependency_graph_cycle_check_top.sv
bench/dependency_graph_cycle_check_top_tb.sv
